### design/matrix_multiply_4x4_assert.svh
// Assertion macros for the matrix multiplier checker
`ifndef MATRIX_MULTIPLY_4X4_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_ASSERT_SVH

// antecedent in this cycle implies consequent in the next
`define MM4_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define MM4_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### design/mm4_pkg.sv
// Shared types and constants for the matrix multiplier
package mm4_pkg;

	localparam int DIM_DEF  = 4;
	localparam int FRAC_DEF = 16;
	localparam int RC_W     = 3;   // row/column field, enough for the largest dimension
	localparam int IDX_W    = 4;
	localparam int VAL_W    = 32;

	typedef struct packed {
		logic                    matrix_select;
		logic [IDX_W-1:0]        element_index;
		logic signed [VAL_W-1:0] element_value;
		logic                    start_compute;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        result_index;
		logic signed [VAL_W-1:0] result_value;
		logic                    last_result;
	} out_item_t;

	typedef struct packed {
		logic                    en;
		logic                    sel;
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] value;
	} wr_t;

	typedef struct packed {
		logic [RC_W-1:0]  row;
		logic [RC_W-1:0]  col;
		logic [IDX_W-1:0] idx;
		logic             last;
	} tok_t;

endpackage

### design/matrix_multiply_4x4.sv
// Top level: fixed-point matrix multiplier built from a chain of MAC cells
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------
//  load     | load_valid / load_stall      | load   (in_item_t)
//  result   | result_valid / result_stall  | result (out_item_t)
//
// One load is accepted per cycle while load_stall is low. A compute issues DIM*DIM
// row/column tokens, one per cycle while the result is not stalled, through DIM
// cells of two stages each plus the output register.
// load_stall is high while tokens are issued or still in the cell chain.
// A stalled result freezes the whole chain. Reset clears only control state.
module matrix_multiply_4x4 import mm4_pkg::*; #(
	parameter int DIM       = DIM_DEF,
	parameter int FRAC_BITS = FRAC_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load_valid,
	output logic      load_stall,
	input  in_item_t  load,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	localparam int AW    = $clog2(DIM);
	localparam int NW    = $clog2(DIM*DIM);
	localparam int ACCW  = 64 + $clog2(DIM);

	logic          accept, adv, busy;
	wr_t           wr;
	logic          run_q;
	logic [AW-1:0] i_q, c_q;
	logic [NW-1:0] n_q;

	logic                   v_w    [DIM+1];
	tok_t                   tok_w  [DIM+1];
	logic signed [ACCW-1:0] psum_w [DIM+1];
	logic [DIM-1:0]         act_w;

	assign accept = load_valid && !load_stall;
	assign adv    = !(result_valid && result_stall);
	assign busy   = run_q || (|act_w);
	assign load_stall = busy;

	assign wr.en    = accept;
	assign wr.sel   = load.matrix_select;
	assign wr.idx   = load.element_index;
	assign wr.value = load.element_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q   <= '0;
			c_q   <= '0;
			n_q   <= '0;
		end else if (accept && load.start_compute) begin
			run_q <= 1'b1;
			i_q   <= '0;
			c_q   <= '0;
			n_q   <= '0;
		end else if (run_q && adv) begin
			n_q <= n_q + 1'b1;
			if (i_q == AW'(DIM-1)) begin
				i_q <= '0;
				c_q <= c_q + 1'b1;
			end else begin
				i_q <= i_q + 1'b1;
			end
			if (n_q == NW'(DIM*DIM-1)) begin
				run_q <= 1'b0;
			end
		end
	end

	assign v_w[0]       = run_q;
	assign tok_w[0].row = RC_W'(i_q);
	assign tok_w[0].col = RC_W'(c_q);
	assign tok_w[0].idx = IDX_W'(n_q);
	assign tok_w[0].last = (n_q == NW'(DIM*DIM-1));
	assign psum_w[0]    = '0;

	for (genvar k = 0; k < DIM; k++) begin : g_cell
		mm4_cell #(
			.DIM  (DIM),
			.K    (k),
			.ACCW (ACCW)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.adv           (adv),
			.wr            (wr),
			.tok_in_valid  (v_w[k]),
			.tok_in        (tok_w[k]),
			.psum_in       (psum_w[k]),
			.tok_out_valid (v_w[k+1]),
			.tok_out       (tok_w[k+1]),
			.psum_out      (psum_w[k+1]),
			.active        (act_w[k])
		);
	end

	mm4_rnd #(
		.ACCW      (ACCW),
		.FRAC_BITS (FRAC_BITS)
	) u_rnd (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (v_w[DIM]),
		.tok      (tok_w[DIM]),
		.sum      (psum_w[DIM]),
		.valid    (result_valid),
		.item     (result)
	);

endmodule

### design/mm4_cell.sv
// One multiply-accumulate cell: holds column K of A and row K of B
module mm4_cell import mm4_pkg::*; #(
	parameter int DIM  = DIM_DEF,
	parameter int K    = 0,
	parameter int ACCW = 64 + $clog2(DIM)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  wr_t                    wr,
	input  logic                   tok_in_valid,
	input  tok_t                   tok_in,
	input  logic signed [ACCW-1:0] psum_in,
	output logic                   tok_out_valid,
	output tok_t                   tok_out,
	output logic signed [ACCW-1:0] psum_out,
	output logic                   active
);

	localparam int AW = $clog2(DIM);

	logic signed [VAL_W-1:0] a_mem [DIM];
	logic signed [VAL_W-1:0] b_mem [DIM];

	logic          a_hit, b_hit;
	logic [AW-1:0] a_addr, b_addr;

	logic                     v_s1, v_s2;
	tok_t                     tok_s1, tok_s2;
	logic signed [2*VAL_W-1:0] prod_s1;
	logic signed [ACCW-1:0]   psum_s1, sum_s2;

	always_comb begin
		int ix;
		ix = int'(wr.idx);
		a_hit  = 1'b0;
		a_addr = '0;
		b_hit  = 1'b0;
		b_addr = '0;
		if (wr.en && !wr.sel && ix >= K*DIM && ix < K*DIM + DIM) begin
			a_hit  = 1'b1;
			a_addr = AW'(ix - K*DIM);
		end
		for (int c = 0; c < DIM; c++) begin
			if (wr.en && wr.sel && ix == c*DIM + K) begin
				b_hit  = 1'b1;
				b_addr = AW'(c);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (a_hit) begin
			a_mem[a_addr] <= wr.value;
		end
		if (b_hit) begin
			b_mem[b_addr] <= wr.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= tok_in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s1  <= tok_in;
			psum_s1 <= psum_in;
			prod_s1 <= a_mem[tok_in.row[AW-1:0]] * b_mem[tok_in.col[AW-1:0]];
			tok_s2  <= tok_s1;
			sum_s2  <= psum_s1 + ACCW'(prod_s1);
		end
	end

	assign tok_out_valid = v_s2;
	assign tok_out       = tok_s2;
	assign psum_out      = sum_s2;
	assign active        = v_s1 | v_s2;

endmodule

### design/mm4_rnd.sv
// Round-to-nearest, saturation and output register
module mm4_rnd import mm4_pkg::*; #(
	parameter int ACCW      = 66,
	parameter int FRAC_BITS = FRAC_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  tok_t                   tok,
	input  logic signed [ACCW-1:0] sum,
	output logic                   valid,
	output out_item_t              item
);

	localparam logic signed [ACCW-1:0] HALF = (ACCW'(1) << FRAC_BITS) >> 1;

	logic signed [ACCW-1:0]  rounded, shifted;
	logic [ACCW-VAL_W:0]     hi;
	logic signed [VAL_W-1:0] sat;
	logic                    valid_q;
	out_item_t               item_q;

	always_comb begin
		rounded = sum + HALF;
		shifted = rounded >>> FRAC_BITS;
		hi      = shifted[ACCW-1:VAL_W-1];
		if (&hi || ~|hi) begin
			sat = shifted[VAL_W-1:0];
		end else if (shifted[ACCW-1]) begin
			sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q.result_index <= tok.idx;
			item_q.result_value <= sat;
			item_q.last_result  <= tok.last;
		end
	end

	assign valid = valid_q;
	assign item  = item_q;

endmodule

### design/mm4_chk.sv
// Port-level checker for the matrix multiplier, bound to the top level
`include "matrix_multiply_4x4_assert.svh"

module mm4_chk import mm4_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      load_valid,
	input logic      load_stall,
	input in_item_t  load,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	`MM4_ASSERT_NEXT(a_load_hold, clk, arst_n, load_valid && load_stall, $stable(load), "stalled load transaction changed")
	`MM4_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result transaction dropped or changed")
	`MM4_ASSERT_NEXT(a_compute_busy, clk, arst_n, load_valid && !load_stall && load.start_compute, load_stall, "compute transaction did not make the block busy")
	`MM4_ASSERT_NEXT(a_idle_quiet, clk, arst_n, !load_stall && (!result_valid || !result_stall), !result_valid, "result appeared while idle")

endmodule

bind matrix_multiply_4x4 mm4_chk u_chk (.*);

### tb/matrix_multiply_4x4_tb.sv
// Self-checking testbench for the 4x4 fixed-point matrix multiplier
`timescale 1ns / 100ps

module matrix_multiply_4x4_tb import mm4_pkg::*; ();

	localparam int DIM          = DIM_DEF;
	localparam int FRAC         = FRAC_DEF;
	localparam int CELLS        = DIM * DIM;
	localparam int DRAIN_CYCLES = 2 * (CELLS + 2 * DIM);
	localparam int DRAIN_LIMIT  = 50000;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      load_valid;
	logic      load_stall;
	in_item_t  load;
	logic      result_valid;
	logic      result_stall;
	out_item_t result;

	logic signed [VAL_W-1:0] left_mat  [CELLS];
	logic signed [VAL_W-1:0] right_mat [CELLS];
	out_item_t               expected_results [$];

	int fail_count    = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles   = 0;

	matrix_multiply_4x4 #(
		.DIM       (DIM),
		.FRAC_BITS (FRAC)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (load_valid),
		.load_stall   (load_stall),
		.load         (load),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic signed [VAL_W-1:0] round_saturate(logic signed [127:0] sum);
		logic signed [127:0] r;
		r = (sum + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
		if (r > 128'sd2147483647)
			return 32'sh7FFFFFFF;
		if (r < -(128'sd2147483648))
			return 32'sh80000000;
		return r[VAL_W-1:0];
	endfunction

	// store the element, and on compute queue the full product
	task automatic apply_transaction(in_item_t it);
		logic signed [127:0] acc;
		logic signed [63:0]  a;
		logic signed [63:0]  b;
		out_item_t           res;
		int                  n;
		if (it.element_index < CELLS) begin
			if (it.matrix_select)
				right_mat[it.element_index] = it.element_value;
			else
				left_mat[it.element_index] = it.element_value;
		end
		if (it.start_compute) begin
			n = 0;
			for (int c = 0; c < DIM; c++) begin
				for (int i = 0; i < DIM; i++) begin
					acc = '0;
					for (int k = 0; k < DIM; k++) begin
						a = left_mat[k * DIM + i];
						b = right_mat[c * DIM + k];
						acc = acc + a * b;
					end
					res.result_index = IDX_W'(c * DIM + i);
					res.result_value = round_saturate(acc);
					res.last_result  = (n == CELLS - 1);
					expected_results.push_back(res);
					n++;
				end
			end
		end
	endtask

	task automatic send_elem(bit sel, int idx, logic [VAL_W-1:0] value, bit go);
		in_item_t it;
		it.matrix_select = sel;
		it.element_index = IDX_W'(idx);
		it.element_value = value;
		it.start_compute = go;
		while ($urandom_range(99) < send_idle_pct) begin
			load_valid <= 1'b0;
			@(posedge clk);
		end
		load       <= it;
		load_valid <= 1'b1;
		@(posedge clk);
		while (load_stall)
			@(posedge clk);
		apply_transaction(it);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		load_valid <= 1'b0;
		while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] rand_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5, 6:    v = $urandom_range(32'h0020_0000) - 32'h0010_0000;
			7: begin
				case ($urandom_range(4))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'h0000_0000;
					3: v = 32'hFFFF_FFFF;
					default: v = 32'h0001_0000;
				endcase
			end
			default: v = $urandom_range(32'h0080_0000) - 32'h0040_0000;
		endcase
		return v;
	endfunction

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			result_stall <= 1'b1;
			hold_cycles  <= hold_cycles - 1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t exp_res;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: index %0d value %h", result.result_index,
					result.result_value);
				fail_count++;
			end else begin
				exp_res = expected_results.pop_front();
				if (result.result_index !== exp_res.result_index) begin
					$error("result_index: expected %0d, actual %0d",
						exp_res.result_index, result.result_index);
					fail_count++;
				end
				if (result.result_value !== exp_res.result_value) begin
					$error("result_value: expected %h, actual %h",
						exp_res.result_value, result.result_value);
					fail_count++;
				end
				if (result.last_result !== exp_res.last_result) begin
					$error("last_result: expected %0d, actual %0d",
						exp_res.last_result, result.last_result);
					fail_count++;
				end
			end
		end
	end

	// identity times edge-value matrix, then saturation and rounding ties
	task automatic test_directed();
		logic [VAL_W-1:0] edge_vals [CELLS];
		edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'h0000_8000,
			32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_8000, 32'h8000_8000,
			32'h1234_5678, 32'hEDCB_A987, 32'h0000_FFFF, 32'hFFFF_8001};
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int e = 0; e < CELLS; e++)
			send_elem(1'b0, e, (e % (DIM + 1) == 0) ? 32'h0001_0000 : 32'h0, 1'b0);
		for (int e = 0; e < CELLS; e++)
			send_elem(1'b1, e, edge_vals[e], e == CELLS - 1);
		send_elem(1'b0, 0, 32'h7FFF_FFFF, 1'b1);    // positive saturation
		send_elem(1'b1, 0, 32'h8000_0000, 1'b1);    // negative saturation
		send_elem(1'b0, 0, 32'h8000_0000, 1'b1);    // min times min
		send_elem(1'b0, 0, 32'h0000_0001, 1'b0);
		send_elem(1'b1, 0, 32'h0000_8000, 1'b1);    // tie, positive
		send_elem(1'b1, 0, 32'hFFFF_8000, 1'b1);    // tie, negative
		send_elem(1'b1, 0, 32'hFFFF_7FFF, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
		int  sent;
		bit  sel;
		sent          = 0;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				sel = 1'($urandom_range(1));
				for (int e = 0; e < CELLS; e++)
					send_elem(sel, e, rand_value(), e == CELLS - 1);
				sent += CELLS;
			end else begin
				send_elem(1'($urandom_range(1)), $urandom_range(CELLS - 1), rand_value(),
					$urandom_range(5) == 0);
				sent++;
			end
			if ($urandom_range(39) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	// long receiver hold-off while computes keep coming
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 20;
		hold_cycles   = 150;
		for (int n = 0; n < 4; n++)
			send_elem(1'($urandom_range(1)), $urandom_range(CELLS - 1), rand_value(), 1'b1);
		send_elem(1'b0, $urandom_range(CELLS - 1), rand_value(), 1'b0);
		wait_drained();
	endtask

	initial begin
		arst_n       = 1'b0;
		load_valid   = 1'b0;
		load         = '0;
		result_stall = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(37, 79, 75);
		test_random_traffic(79, 37, 75);
		test_random_traffic(0, 0, 75);
		test_backpressure();

		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### matrix_multiply_4x4.f
+incdir+design
design/mm4_pkg.sv
design/mm4_cell.sv
design/mm4_rnd.sv
design/matrix_multiply_4x4.sv
design/mm4_chk.sv
tb/matrix_multiply_4x4_tb.sv
